FILE: hdl/caesar_message_checksum_transform_assert.svh
// Assertion macros shared by the checkers of the Caesar message checksum block.
// Depends on a clock named clock and an active-high reset named reset in scope.
`ifndef CAESAR_MESSAGE_CHECKSUM_TRANSFORM_ASSERT_SVH
`define CAESAR_MESSAGE_CHECKSUM_TRANSFORM_ASSERT_SVH

// Same-cycle implication: the consequent must hold whenever the antecedent does.
`define CMCT_ASSERT_IMPLY(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication: the consequent must hold in the cycle after the antecedent.
`define CMCT_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: hdl/cmct_pkg.sv
// Package for the Caesar message checksum block: payload types, constants and
// the per-byte helper functions. No dependencies.
`default_nettype none

package cmct_pkg;

   localparam int LENGTH_BITS = 16;
   localparam logic [LENGTH_BITS-1:0] LEN_MAX = '1;
   localparam int HDR_BYTES = 8;
   localparam int ALPHA_COUNT = 26;
   localparam int CASE_GAP = 32;
   localparam int LEN_FIELD_START = 4;
   localparam logic [7:0] CHAR_UP_A = 8'h41;
   localparam logic [7:0] CHAR_UP_Z = 8'h5A;
   localparam logic [7:0] CHAR_LO_A = 8'h61;
   localparam logic [7:0] CHAR_LO_Z = 8'h7A;
   localparam logic [15:0] RESP_LEN_MAX = 16'hFFFF;
   localparam logic OP_FORWARD = 1'b0;

   typedef struct packed {
      logic [7:0] in_byte;
      logic       in_last;
   } req_type;

   typedef struct packed {
      logic [7:0]  out_byte;
      logic        byte_valid;
      logic        is_last;
      logic        msg_ok;
      logic [15:0] resp_checksum;
      logic [15:0] resp_length;
   } rsp_type;

   // Request held in the input register.
   typedef struct packed {
      logic    valid;
      req_type data;
   } stage_type;

   // Result handed to the output register.
   typedef struct packed {
      logic    load;
      rsp_type data;
   } rsp_load_type;

   // Three-operand one's-complement add with end-around carry.
   function automatic logic [15:0] ones_add3(input logic [15:0] a, input logic [15:0] b,
                                             input logic [15:0] c);
      logic [17:0] s;
      logic [16:0] f;
      s = 18'(a) + 18'(b) + 18'(c);
      f = 17'(s[15:0]) + 17'(s[17:16]);
      return f[15:0] + 16'(f[16]);
   endfunction

   // Remainder by the alphabet size through four restoring subtract steps.
   function automatic logic [4:0] mod_alpha(input logic [7:0] b);
      logic [8:0] r;
      r = {1'b0, b};
      for (int k = 3; k >= 0; k--) begin
         if (r >= 9'(ALPHA_COUNT << k)) begin
            r = r - 9'(ALPHA_COUNT << k);
         end
      end
      return r[4:0];
   endfunction

   // Lowercase a letter and shift it within the alphabet; other bytes pass.
   function automatic logic [7:0] caesar_conv(input logic [7:0] b, input logic op,
                                              input logic [4:0] shift);
      logic [7:0] c;
      logic [7:0] r;
      c = b;
      if (c >= CHAR_UP_A && c <= CHAR_UP_Z) begin
         c = c + 8'(CASE_GAP);
      end
      r = c;
      if (c >= CHAR_LO_A && c <= CHAR_LO_Z) begin
         if (op == OP_FORWARD) begin
            r = c + 8'(shift);
            if (r > CHAR_LO_Z) begin
               r = r - 8'(ALPHA_COUNT);
            end
         end else begin
            if (c < CHAR_LO_A + 8'(shift)) begin
               r = c + 8'(ALPHA_COUNT) - 8'(shift);
            end else begin
               r = c - 8'(shift);
            end
         end
      end
      return r;
   endfunction

   // Reply length: at least the header, saturated to 16 bits.
   function automatic logic [15:0] reply_length(input logic [LENGTH_BITS-1:0] total);
      logic [32:0] t;
      t = 33'(total);
      if (t < 33'(HDR_BYTES)) begin
         t = 33'(HDR_BYTES);
      end
      if (t > 33'(RESP_LEN_MAX)) begin
         t = 33'(RESP_LEN_MAX);
      end
      return t[15:0];
   endfunction

endpackage

`default_nettype wire

FILE: hdl/cmct_req_reg.sv
// Input register of the Caesar message checksum block.
// Depends on cmct_pkg for the request and stage types.
`default_nettype none

module cmct_req_reg
   import cmct_pkg::*;
(
   input  wire logic      clock,
   input  wire logic      reset,
   input  wire logic      req_valid,
   output logic           req_ready,
   input  wire req_type   req_payload,
   input  wire logic      advance,
   output stage_type      stage
);

   logic    valid_ff;
   logic    valid_in;
   req_type data_ff;

   // A held request may be replaced in the same cycle it moves on.
   assign req_ready = !valid_ff || advance;
   assign valid_in  = req_valid || (valid_ff && !advance);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (req_valid && req_ready) begin
         data_ff <= req_payload;
      end
   end

   assign stage.valid = valid_ff;
   assign stage.data  = data_ff;

endmodule

`default_nettype wire

FILE: hdl/cmct_engine.sv
// Per-byte message engine: header capture, Caesar conversion and the two
// running one's-complement sums. Depends on cmct_pkg.
`default_nettype none

module cmct_engine
   import cmct_pkg::*;
(
   input  wire logic      clock,
   input  wire logic      reset,
   input  wire stage_type stage,
   input  wire logic      out_free,
   output logic           advance,
   output rsp_load_type   rsp_load
);

   logic [LENGTH_BITS-1:0] pos_ff, pos_in;
   logic                   op_ff, op_in;
   logic [4:0]             shift_ff, shift_in;
   logic [LENGTH_BITS-1:0] dlen_ff, dlen_in;
   logic [15:0]            vsum_ff, vsum_in;
   logic [15:0]            rsum_ff, rsum_in;
   logic [7:0]             hold_ff, hold_in;
   logic                   err_ff, err_in;

   logic [7:0]             b;
   logic                   last;
   logic                   odd;
   logic                   text;
   logic                   pos_sat;
   logic [LENGTH_BITS-1:0] pos_step;
   logic [LENGTH_BITS+7:0] dlen_shift;
   logic                   dlen_ovf;
   logic                   dlen_byte;
   logic [7:0]             conv;
   logic [7:0]             rbyte;
   logic [15:0]            pair;
   logic [15:0]            rop;
   logic [15:0]            tail;
   logic [15:0]            rlen;
   logic [15:0]            vsum_fin;
   logic [15:0]            rsum_fin;
   logic                   ok;
   logic                   has_result;

   assign b    = stage.data.in_byte;
   assign last = stage.data.in_last;
   assign odd  = pos_ff[0];
   assign text = pos_ff >= LENGTH_BITS'(HDR_BYTES);

   assign pos_sat  = pos_ff == LEN_MAX;
   assign pos_step = pos_sat ? pos_ff : pos_ff + 1'b1;

   // Length field is shifted in big-endian; bits pushed off the top flag it.
   assign dlen_shift = {dlen_ff, b};
   assign dlen_byte  = !text && pos_ff >= LENGTH_BITS'(LEN_FIELD_START);
   assign dlen_ovf   = dlen_byte && (dlen_ff[LENGTH_BITS-1 -: 8] != 8'h00);

   assign conv  = text ? caesar_conv(b, op_ff, shift_ff) : 8'h00;
   assign rbyte = text ? conv : b;

   always_comb begin
      // Received sum works on little-endian pairs.
      pair = odd ? {b, hold_ff} : 16'h0000;
      hold_in = odd ? hold_ff : b;
      // Reply sum takes the op and shift bytes and the converted text.
      if (text || pos_ff < LENGTH_BITS'(2)) begin
         rop = odd ? {rbyte, 8'h00} : {8'h00, rbyte};
      end else begin
         rop = 16'h0000;
      end
      op_in    = (pos_ff == '0) ? b[0] : op_ff;
      shift_in = (pos_ff == LENGTH_BITS'(1)) ? mod_alpha(b) : shift_ff;
      dlen_in  = dlen_byte ? dlen_shift[LENGTH_BITS-1:0] : dlen_ff;
      err_in   = err_ff || dlen_ovf || pos_sat;
      pos_in   = pos_step;
      vsum_in  = ones_add3(vsum_ff, pair, 16'h0000);
      rsum_in  = ones_add3(rsum_ff, rop, 16'h0000);
   end

   // Closing figures: an odd tail byte counts as a low byte; the reply
   // length field adds as one byte-swapped word.
   assign rlen     = reply_length(pos_step);
   assign tail     = pos_step[0] ? {8'h00, hold_in} : 16'h0000;
   assign vsum_fin = ones_add3(vsum_ff, pair, tail);
   assign rsum_fin = ones_add3(rsum_ff, rop, {rlen[7:0], rlen[15:8]});
   assign ok       = (vsum_fin == 16'hFFFF) && !err_in &&
                     (pos_step >= LENGTH_BITS'(HDR_BYTES)) && (pos_step == dlen_in);

   assign has_result = text || last;
   assign advance    = stage.valid && (!has_result || out_free);

   always_comb begin
      rsp_load.load               = advance && has_result;
      rsp_load.data.out_byte      = conv;
      rsp_load.data.byte_valid    = text;
      rsp_load.data.is_last       = last;
      rsp_load.data.msg_ok        = last && ok;
      rsp_load.data.resp_checksum = last ? ~rsum_fin : 16'h0000;
      rsp_load.data.resp_length   = last ? rlen : 16'h0000;
   end

   always_ff @(posedge clock) begin
      if (reset || (advance && last)) begin
         pos_ff   <= '0;
         op_ff    <= 1'b0;
         shift_ff <= '0;
         dlen_ff  <= '0;
         vsum_ff  <= '0;
         rsum_ff  <= '0;
         hold_ff  <= '0;
         err_ff   <= 1'b0;
      end else if (advance) begin
         pos_ff   <= pos_in;
         op_ff    <= op_in;
         shift_ff <= shift_in;
         dlen_ff  <= dlen_in;
         vsum_ff  <= vsum_in;
         rsum_ff  <= rsum_in;
         hold_ff  <= hold_in;
         err_ff   <= err_in;
      end
   end

endmodule

`default_nettype wire

FILE: hdl/cmct_rsp_reg.sv
// Output register of the Caesar message checksum block.
// Depends on cmct_pkg for the result types.
`default_nettype none

module cmct_rsp_reg
   import cmct_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire rsp_load_type rsp_load,
   output logic              out_free,
   output logic              rsp_valid,
   input  wire logic         rsp_ready,
   output rsp_type           rsp_payload
);

   logic    valid_ff;
   logic    valid_in;
   rsp_type data_ff;

   assign out_free = !valid_ff || rsp_ready;
   assign valid_in = rsp_load.load || (valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (rsp_load.load) begin
         data_ff <= rsp_load.data;
      end
   end

   assign rsp_valid   = valid_ff;
   assign rsp_payload = data_ff;

endmodule

`default_nettype wire

FILE: hdl/caesar_message_checksum_transform.sv
// Caesar message checksum transform, top level. Depends on cmct_pkg,
// cmct_req_reg, cmct_engine and cmct_rsp_reg.
// A request goes from the input register through the engine into the output register.
// Throughput: one request per cycle while the output register can take a result,
// set by the single-pass engine between the input register and the output register.
// Reset (synchronous, active high) empties both registers and clears all message state.
`default_nettype none

// A message arrives one byte per request: an 8-byte header (operation, shift,
// little-endian checksum, big-endian total length) followed by the text.
// Header bytes produce no result unless they close the message. Each text
// byte produces one result carrying the converted byte. The closing byte's
// result also carries the verify flag, the reply checksum and the reply length,
// after which the message state returns to its reset value.
module caesar_message_checksum_transform
   import cmct_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_ready,
   input  wire req_type req_payload,
   output logic         rsp_valid,
   input  wire logic    rsp_ready,
   output rsp_type      rsp_payload
);

   stage_type    stage;
   rsp_load_type rsp_load;
   logic         advance;
   logic         out_free;

   // The input register holds one request; it refills in the same cycle that
   // the engine consumes the held request, so requests stream without gaps.
   cmct_req_reg u_req_reg (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .advance     (advance),
      .stage       (stage)
   );

   // The engine updates the message state only when the held request moves
   // on: either it produces no result, or the output register can take one.
   cmct_engine u_engine (
      .clock    (clock),
      .reset    (reset),
      .stage    (stage),
      .out_free (out_free),
      .advance  (advance),
      .rsp_load (rsp_load)
   );

   // The output register holds one result; while it waits for the consumer, requests
   // that produce no result still pass, but the next one that does stalls the engine.
   cmct_rsp_reg u_rsp_reg (
      .clock       (clock),
      .reset       (reset),
      .rsp_load    (rsp_load),
      .out_free    (out_free),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

endmodule

`default_nettype wire

FILE: hdl/cmct_checker.sv
// Port-level checker for the Caesar message checksum block and its bind.
// Depends on cmct_pkg and caesar_message_checksum_transform_assert.svh.
`default_nettype none

`include "caesar_message_checksum_transform_assert.svh"

module cmct_checker
   import cmct_pkg::*;
(
   input wire logic    clock,
   input wire logic    reset,
   input wire logic    rsp_valid,
   input wire logic    rsp_ready,
   input wire rsp_type rsp_payload
);

   `CMCT_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready,
      rsp_valid && $stable(rsp_payload), "stalled request result changed")
   `CMCT_ASSERT_IMPLY(a_rsp_kind, rsp_valid,
      rsp_payload.byte_valid || rsp_payload.is_last, "result carries neither text nor close")
   `CMCT_ASSERT_IMPLY(a_mid_zero, rsp_valid && !rsp_payload.is_last,
      !rsp_payload.msg_ok && rsp_payload.resp_checksum == 16'h0000 &&
      rsp_payload.resp_length == 16'h0000, "closing fields set on a text result")
   `CMCT_ASSERT_IMPLY(a_len_min, rsp_valid && rsp_payload.is_last,
      rsp_payload.resp_length >= 16'(HDR_BYTES), "reply length below header size")
   `CMCT_ASSERT_IMPLY(a_byte_zero, rsp_valid && !rsp_payload.byte_valid,
      rsp_payload.out_byte == 8'h00, "byte set on a result without text")

endmodule

bind caesar_message_checksum_transform cmct_checker u_cmct_checker (
   .clock       (clock),
   .reset       (reset),
   .rsp_valid   (rsp_valid),
   .rsp_ready   (rsp_ready),
   .rsp_payload (rsp_payload)
);

`default_nettype wire
